// ----- rtl/nlpv_pkg.sv -----
// Shared widths, constants and types of the nearest lattice point block.
`timescale 1ns / 1ps
package nlpv_pkg;

   localparam int COMP_W      = 21;
   localparam int REG_W       = 63;
   localparam int Q_W         = 32;
   localparam int IDX_W       = 13;
   localparam int CRS_W       = 43;
   localparam int NUM_W       = 57;
   localparam int DEN_W       = 64;
   localparam int DIV_BITS    = 32;
   localparam int DIV_LAT     = DIV_BITS + 2;
   localparam int REQ_DATA_W  = 96;
   localparam int RSP_DATA_W  = 136;
   localparam int RSP_USER_W  = 2;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 64;

   localparam int IDX_HI_MAG  = 4095;
   localparam int IDX_LO_MAG  = 4096;
   localparam logic [IDX_W-1:0] IDX_HI = 13'h0FFF;
   localparam logic [IDX_W-1:0] IDX_LO = 13'h1000;

   localparam logic [DIV_BITS:0] LIM_POS = 33'h0_7FFF_FFFF;
   localparam logic [DIV_BITS:0] LIM_NEG = 33'h0_8000_0000;

   typedef struct packed {
      logic                big;
      logic [DIV_BITS:0]   quo;
   } div_res_type;

endpackage

// ----- rtl/nlpv_div_lane.sv -----
// Pipelined divider lane: round(num * 2^FRAC_SUM / den), one quotient bit per stage.
`timescale 1ns / 1ps
module nlpv_div_lane import nlpv_pkg::*; #(
   parameter int FRAC_SUM = 36
) (
   input  logic                clock,
   input  logic                en,
   input  logic [NUM_W-1:0]    num_mag,
   input  logic [DEN_W-1:0]    den,
   output div_res_type         res
);

   localparam int NSH_W = NUM_W + FRAC_SUM;
   localparam int R0_W  = NSH_W - DIV_BITS;
   localparam int CW    = (R0_W > DEN_W) ? R0_W : DEN_W;

   logic [NSH_W-1:0]    nsh;
   logic [CW-1:0]       r0c;
   logic [CW-1:0]       dc;

   logic [DEN_W-1:0]    rem_ff [DIV_BITS+1];
   logic [DIV_BITS-1:0] low_ff [DIV_BITS+1];
   logic [DIV_BITS-1:0] quo_ff [DIV_BITS+1];
   logic                big_ff [DIV_BITS+1];
   div_res_type         res_ff;
   logic                up;

   always_comb begin
      nsh = {num_mag, {FRAC_SUM{1'b0}}};
      r0c = CW'(nsh[NSH_W-1:DIV_BITS]);
      dc  = CW'(den);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= r0c[DEN_W-1:0];
         low_ff[0] <= nsh[DIV_BITS-1:0];
         quo_ff[0] <= '0;
         big_ff[0] <= (r0c >= dc);
      end
   end

   for (genvar k = 0; k < DIV_BITS; k++) begin : g_bit
      logic [DEN_W:0] t;
      logic [DEN_W:0] diff;
      logic           ge;

      always_comb begin
         t    = {rem_ff[k], low_ff[k][DIV_BITS-1]};
         ge   = (t >= {1'b0, den});
         diff = t - {1'b0, den};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
            low_ff[k+1] <= {low_ff[k][DIV_BITS-2:0], 1'b0};
            quo_ff[k+1] <= {quo_ff[k][DIV_BITS-2:0], ge};
            big_ff[k+1] <= big_ff[k];
         end
      end
   end

   assign up = ({rem_ff[DIV_BITS], 1'b0} >= {1'b0, den});

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff.big <= big_ff[DIV_BITS];
         res_ff.quo <= {1'b0, quo_ff[DIV_BITS]} + (DIV_BITS+1)'(up);
      end
   end

   assign res = res_ff;

endmodule

// ----- rtl/nearest_lattice_point_vector.sv -----
// Top level: snaps a scattering vector to the nearest point of the configured lattice.
// Path from the accepting edge to rsp_tvalid: 8 front stages, 34 divider stages, one output
// queue write; the first front stage loads at the accepting edge.
// Throughput: one request per cycle while req_tready is high; three divider lanes of 32
// pipelined quotient-bit stages set the depth. A two-entry output queue decouples rsp_tready;
// req_tready drops only while it is full. Reset clears the cell registers, valid bits and
// queue; the cell products settle through the cm, crs, dp, det and dmag registers after a write.
`timescale 1ns / 1ps
module nearest_lattice_point_vector import nlpv_pkg::*; #(
   parameter int Q_FRAC_BITS    = 24,
   parameter int AXIS_FRAC_BITS = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [REQ_DATA_W-1:0]   req_tdata,   // q_x, q_y, q_z
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RSP_DATA_W-1:0]   rsp_tdata,   // g_x, g_y, g_z, index_h, index_k, index_l, pad
   output logic [RSP_USER_W-1:0]   rsp_tuser,   // singular, overflow
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready
);

   localparam int FRAC_SUM = Q_FRAC_BITS + AXIS_FRAC_BITS;
   localparam int PROD_W   = Q_W + COMP_W;
   localparam int DOT_W    = PROD_W + 2;
   localparam int RND_W    = (FRAC_SUM + 2 > DOT_W) ? FRAC_SUM + 2 : DOT_W;
   localparam int CP_W     = 2 * COMP_W;
   localparam int DP_W     = COMP_W + CRS_W;
   localparam int DET_W    = DP_W + 2;
   localparam int IP_W     = IDX_W + CRS_W;
   localparam int NV       = 8 + DIV_LAT;
   localparam logic [FRAC_SUM-1:0] HALF = {1'b1, {(FRAC_SUM-1){1'b0}}};

   typedef enum logic [1:0] {
      REG_AXIS_A = 2'd0,
      REG_AXIS_B = 2'd1,
      REG_AXIS_C = 2'd2
   } reg_sel_type;

   typedef struct packed {
      logic [2:0][IDX_W-1:0] idx;
      logic                  iovf;
      logic [2:0]            neg;
      logic                  sing;
   } side_type;

   typedef struct packed {
      logic [RSP_USER_W-1:0] tuser;
      logic [RSP_DATA_W-1:0] tdata;
   } out_type;

   function automatic int nx(input int k);
      return (k == 2) ? 0 : k + 1;
   endfunction

   // configuration registers
   logic [REG_W-1:0]  axis_ff [3];
   reg_sel_type       csr_sel;
   logic              csr_wr;

   assign csr_sel    = reg_sel_type'(csr_paddr[CSR_ADDR_W-1:3]);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff[0] <= '0;
         axis_ff[1] <= '0;
         axis_ff[2] <= '0;
      end else if (csr_wr) begin
         unique case (csr_sel)
            REG_AXIS_A: axis_ff[0] <= csr_pwdata[REG_W-1:0];
            REG_AXIS_B: axis_ff[1] <= csr_pwdata[REG_W-1:0];
            REG_AXIS_C: axis_ff[2] <= csr_pwdata[REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         REG_AXIS_A: csr_prdata = {1'b0, axis_ff[0]};
         REG_AXIS_B: csr_prdata = {1'b0, axis_ff[1]};
         REG_AXIS_C: csr_prdata = {1'b0, axis_ff[2]};
         default:    csr_prdata = '0;
      endcase
   end

   // cell-derived products
   logic signed [COMP_W-1:0] ax [3][3];
   logic signed [CP_W-1:0]   cm_ff [3][3][2];
   logic signed [CRS_W-1:0]  crs_ff [3][3];
   logic signed [DP_W-1:0]   dp_ff [3];
   logic signed [DET_W-1:0]  det_ff;
   logic signed [DET_W-1:0]  det_abs;
   logic                     det_neg_ff;
   logic                     det_zero_ff;
   logic [DEN_W-1:0]         dmag_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            ax[i][j] = axis_ff[i][COMP_W*j +: COMP_W];
         end
      end
   end

   assign det_abs = det_ff[DET_W-1] ? -det_ff : det_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            cm_ff[i][j][0] <= ax[nx(i)][nx(j)] * ax[nx(nx(i))][nx(nx(j))];
            cm_ff[i][j][1] <= ax[nx(i)][nx(nx(j))] * ax[nx(nx(i))][nx(j)];
            crs_ff[i][j]   <= CRS_W'(cm_ff[i][j][0]) - CRS_W'(cm_ff[i][j][1]);
         end
         dp_ff[i] <= ax[0][i] * crs_ff[0][i];
      end
      det_ff      <= DET_W'(dp_ff[0]) + DET_W'(dp_ff[1]) + DET_W'(dp_ff[2]);
      det_neg_ff  <= det_ff[DET_W-1];
      det_zero_ff <= (det_ff == '0);
      dmag_ff     <= det_abs[DEN_W-1:0];
   end

   // pipeline control
   logic [NV-1:0] vld_ff;
   logic [1:0]    cnt_ff;
   logic          en;
   logic          push;
   logic          pop;

   assign en         = ~cnt_ff[1];
   assign req_tready = en;
   assign push       = en & vld_ff[NV-1];
   assign pop        = rsp_tvalid & rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NV-2:0], req_tvalid};
      end
   end

   // front stages: dot products, rounding, numerators
   logic signed [Q_W-1:0]    qv_ff [3];
   logic signed [PROD_W-1:0] qp_ff [3][3];
   logic signed [DOT_W-1:0]  dot_ff [3];
   logic signed [DOT_W-1:0]  dot_abs [3];
   logic [RND_W-1:0]         rmag_ff [3];
   logic                     dneg_ff [3];
   logic [RND_W-1:0]         qt [3];
   logic [RND_W-1:0]         qr [3];
   logic [FRAC_SUM-1:0]      rem [3];
   logic                     up [3];
   logic [IDX_W-1:0]         idx_in [3];
   logic [2:0]               iovf_in;
   logic [IDX_W-1:0]         idx_ff [3];
   logic                     iovf_ff;
   logic signed [IP_W-1:0]   ip_ff [3][3];
   logic signed [NUM_W-1:0]  num_ff [3];
   logic signed [NUM_W-1:0]  num_abs [3];
   logic [NUM_W-1:0]         nm_ff [3];
   side_type                 side6_ff;
   side_type                 side7_ff;
   side_type                 side8_ff;
   side_type                 side_dly_ff [DIV_LAT];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dot_abs[i] = dot_ff[i][DOT_W-1] ? -dot_ff[i] : dot_ff[i];
         num_abs[i] = num_ff[i][NUM_W-1] ? -num_ff[i] : num_ff[i];
         qt[i]      = rmag_ff[i] >> FRAC_SUM;
         rem[i]     = rmag_ff[i][FRAC_SUM-1:0];
         up[i]      = (rem[i] > HALF) || ((rem[i] == HALF) && qt[i][0]);
         qr[i]      = qt[i] + RND_W'(up[i]);
         iovf_in[i] = 1'b0;
         if (!dneg_ff[i]) begin
            if (qr[i] > RND_W'(IDX_HI_MAG)) begin
               idx_in[i]  = IDX_HI;
               iovf_in[i] = 1'b1;
            end else begin
               idx_in[i]  = qr[i][IDX_W-1:0];
            end
         end else begin
            if (qr[i] > RND_W'(IDX_LO_MAG)) begin
               idx_in[i]  = IDX_LO;
               iovf_in[i] = 1'b1;
            end else begin
               idx_in[i]  = -qr[i][IDX_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            qv_ff[i] <= req_tdata[Q_W*i +: Q_W];
            for (int j = 0; j < 3; j++) begin
               qp_ff[i][j] <= qv_ff[j] * ax[i][j];
               ip_ff[i][j] <= $signed(idx_ff[i]) * crs_ff[i][j];
            end
            dot_ff[i]  <= DOT_W'(qp_ff[i][0]) + DOT_W'(qp_ff[i][1]) + DOT_W'(qp_ff[i][2]);
            rmag_ff[i] <= RND_W'($unsigned(dot_abs[i]));
            dneg_ff[i] <= dot_ff[i][DOT_W-1];
            idx_ff[i]  <= idx_in[i];
            num_ff[i]  <= NUM_W'(ip_ff[0][i]) + NUM_W'(ip_ff[1][i]) + NUM_W'(ip_ff[2][i]);
            nm_ff[i]   <= $unsigned(num_abs[i]);
         end
         iovf_ff       <= |iovf_in;
         side6_ff.idx  <= {idx_ff[2], idx_ff[1], idx_ff[0]};
         side6_ff.iovf <= iovf_ff;
         side6_ff.neg  <= '0;
         side6_ff.sing <= 1'b0;
         side7_ff      <= side6_ff;
         side8_ff.idx  <= side7_ff.idx;
         side8_ff.iovf <= side7_ff.iovf;
         side8_ff.neg  <= {num_ff[2][NUM_W-1], num_ff[1][NUM_W-1], num_ff[0][NUM_W-1]}
                          ^ {3{det_neg_ff}};
         side8_ff.sing <= det_zero_ff;
         side_dly_ff[0] <= side8_ff;
         for (int k = 1; k < DIV_LAT; k++) begin
            side_dly_ff[k] <= side_dly_ff[k-1];
         end
      end
   end

   // divider lanes
   div_res_type dres [3];

   for (genvar j = 0; j < 3; j++) begin : g_lane
      nlpv_div_lane #(
         .FRAC_SUM (FRAC_SUM)
      ) u_lane (
         .clock   (clock),
         .en      (en),
         .num_mag (nm_ff[j]),
         .den     (dmag_ff),
         .res     (dres[j])
      );
   end

   // saturation, sign and result assembly
   side_type          sd;
   logic [DIV_BITS:0] lim [3];
   logic [DIV_BITS:0] mg [3];
   logic [2:0]        sat;
   logic [Q_W-1:0]    gv [3];
   out_type           out_in;

   always_comb begin
      sd = side_dly_ff[DIV_LAT-1];
      for (int j = 0; j < 3; j++) begin
         lim[j] = sd.neg[j] ? LIM_NEG : LIM_POS;
         sat[j] = dres[j].big || (dres[j].quo > lim[j]);
         mg[j]  = sat[j] ? lim[j] : dres[j].quo;
         gv[j]  = sd.sing ? '0 : (sd.neg[j] ? -mg[j][Q_W-1:0] : mg[j][Q_W-1:0]);
      end
      out_in.tdata = {1'b0, sd.idx[2], sd.idx[1], sd.idx[0], gv[2], gv[1], gv[0]};
      out_in.tuser = {sd.iovf | (~sd.sing & (|sat)), sd.sing};
   end

   // output queue
   out_type mem_ff [2];
   logic    wp_ff;
   logic    rp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= ~wp_ff;
         end
         if (pop) begin
            rp_ff <= ~rp_ff;
         end
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= out_in;
      end
   end

   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tdata  = mem_ff[rp_ff].tdata;
   assign rsp_tuser  = mem_ff[rp_ff].tuser;

endmodule

// ----- rtl/nlpv_check.sv -----
// Port-level checks of the nearest lattice point block, bound to the top level.
`timescale 1ns / 1ps
module nlpv_check import nlpv_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [RSP_DATA_W-1:0]   rsp_tdata,
   input logic [RSP_USER_W-1:0]   rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[95:0] == 96'd0)
      else $error("singular cell with nonzero vector");

endmodule

bind nearest_lattice_point_vector nlpv_check u_nlpv_check (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ----- dv/nearest_lattice_point_vector_checker.sv -----
// Checker: predicts the lattice point of every request and compares each response.
`timescale 1ns / 1ps
module nearest_lattice_point_vector_checker import nlpv_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tready,
   input  logic [REQ_DATA_W-1:0]   req_tdata,   // q_x, q_y, q_z
   input  logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic [RSP_DATA_W-1:0]   rsp_tdata,   // g_x, g_y, g_z, index_h, index_k, index_l, pad
   input  logic [RSP_USER_W-1:0]   rsp_tuser,   // singular, overflow
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   input  logic                    csr_pready,
   output int                      errors,
   output int                      pending
);

   localparam int AXIS_COUNT = 3;
   localparam int FRAC_SUM   = 24 + 12;

   typedef struct packed {
      logic [Q_W-1:0]   g_x;
      logic [Q_W-1:0]   g_y;
      logic [Q_W-1:0]   g_z;
      logic [IDX_W-1:0] h;
      logic [IDX_W-1:0] k;
      logic [IDX_W-1:0] l;
      logic             singular;
      logic             overflow;
   } lattice_point_type;

   logic [REG_W-1:0]  cell_axis [AXIS_COUNT];
   lattice_point_type point_q [$];

   function automatic longint comp_of(logic [REG_W-1:0] axis, int n);
      logic [COMP_W-1:0] c;
      c = axis[n*COMP_W +: COMP_W];
      return longint'($signed(c));
   endfunction

   function automatic longint round_miller(longint dot, inout logic ovf);
      logic [63:0] mag, quo, rem;
      mag = (dot < 0) ? -dot : dot;
      quo = mag >> FRAC_SUM;
      rem = mag & ((64'd1 << FRAC_SUM) - 1);
      if (rem > (64'd1 << (FRAC_SUM - 1)) || (rem == (64'd1 << (FRAC_SUM - 1)) && quo[0]))
         quo++;
      if (dot >= 0) begin
         if (quo > IDX_HI_MAG) begin
            ovf = 1'b1;
            return IDX_HI_MAG;
         end
         return longint'(quo);
      end
      if (quo > IDX_LO_MAG) begin
         ovf = 1'b1;
         return -IDX_LO_MAG;
      end
      return -longint'(quo);
   endfunction

   function automatic logic [Q_W-1:0] scale_divide(longint num, longint den, inout logic ovf);
      logic          neg;
      logic [127:0]  n, d, quo, rem;
      logic [63:0]   qq, lim;
      neg = (num < 0) != (den < 0);
      n = {64'd0, ((num < 0) ? -num : num)} << FRAC_SUM;
      d = {64'd0, ((den < 0) ? -den : den)};
      quo = n / d;
      rem = n % d;
      qq = {32'd0, quo[31:0]};
      if (rem >= d - rem)
         qq++;
      lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      if ((|quo[127:32]) || qq > lim) begin
         ovf = 1'b1;
         qq = lim;
      end
      qq = neg ? -qq : qq;
      return qq[Q_W-1:0];
   endfunction

   function automatic lattice_point_type snap_to_lattice(logic [REQ_DATA_W-1:0] data);
      lattice_point_type p;
      longint a[3], b[3], c[3], q[3], bc[3], ca[3], ab[3], idx[3], det, num;
      logic ovf;
      logic [Q_W-1:0] g[3];
      ovf = 1'b0;
      for (int j = 0; j < 3; j++) begin
         a[j] = comp_of(cell_axis[0], j);
         b[j] = comp_of(cell_axis[1], j);
         c[j] = comp_of(cell_axis[2], j);
         q[j] = longint'($signed(data[j*Q_W +: Q_W]));
      end
      idx[0] = round_miller(q[0]*a[0] + q[1]*a[1] + q[2]*a[2], ovf);
      idx[1] = round_miller(q[0]*b[0] + q[1]*b[1] + q[2]*b[2], ovf);
      idx[2] = round_miller(q[0]*c[0] + q[1]*c[1] + q[2]*c[2], ovf);
      bc[0] = b[1]*c[2] - b[2]*c[1];
      bc[1] = b[2]*c[0] - b[0]*c[2];
      bc[2] = b[0]*c[1] - b[1]*c[0];
      ca[0] = c[1]*a[2] - c[2]*a[1];
      ca[1] = c[2]*a[0] - c[0]*a[2];
      ca[2] = c[0]*a[1] - c[1]*a[0];
      ab[0] = a[1]*b[2] - a[2]*b[1];
      ab[1] = a[2]*b[0] - a[0]*b[2];
      ab[2] = a[0]*b[1] - a[1]*b[0];
      det = a[0]*bc[0] + a[1]*bc[1] + a[2]*bc[2];
      for (int j = 0; j < 3; j++) begin
         if (det == 0) begin
            g[j] = '0;
         end else begin
            num = idx[0]*bc[j] + idx[1]*ca[j] + idx[2]*ab[j];
            g[j] = scale_divide(num, det, ovf);
         end
      end
      p.g_x = g[0];
      p.g_y = g[1];
      p.g_z = g[2];
      p.h = idx[0][IDX_W-1:0];
      p.k = idx[1][IDX_W-1:0];
      p.l = idx[2][IDX_W-1:0];
      p.singular = (det == 0);
      p.overflow = ovf;
      return p;
   endfunction

   task automatic report(string field, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
      errors++;
   endtask

   always @(posedge clock) begin
      lattice_point_type want, got;
      if (reset) begin
         for (int j = 0; j < AXIS_COUNT; j++)
            cell_axis[j] <= '0;
         point_q.delete();
         errors <= 0;
         pending <= 0;
      end else begin
         if (req_tvalid && req_tready)
            point_q.push_back(snap_to_lattice(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.g_x = rsp_tdata[0 +: Q_W];
            got.g_y = rsp_tdata[Q_W +: Q_W];
            got.g_z = rsp_tdata[2*Q_W +: Q_W];
            got.h = rsp_tdata[3*Q_W +: IDX_W];
            got.k = rsp_tdata[3*Q_W+IDX_W +: IDX_W];
            got.l = rsp_tdata[3*Q_W+2*IDX_W +: IDX_W];
            got.singular = rsp_tuser[0];
            got.overflow = rsp_tuser[1];
            if (point_q.size() == 0) begin
               report("unexpected response", rsp_tdata[63:0], '0);
            end else begin
               want = point_q.pop_front();
               if (got.g_x !== want.g_x) report("g_x", 64'(got.g_x), 64'(want.g_x));
               if (got.g_y !== want.g_y) report("g_y", 64'(got.g_y), 64'(want.g_y));
               if (got.g_z !== want.g_z) report("g_z", 64'(got.g_z), 64'(want.g_z));
               if (got.h !== want.h) report("index_h", 64'(got.h), 64'(want.h));
               if (got.k !== want.k) report("index_k", 64'(got.k), 64'(want.k));
               if (got.l !== want.l) report("index_l", 64'(got.l), 64'(want.l));
               if (got.singular !== want.singular)
                  report("singular", 64'(got.singular), 64'(want.singular));
               if (got.overflow !== want.overflow)
                  report("overflow", 64'(got.overflow), 64'(want.overflow));
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
               && csr_paddr[4:3] < AXIS_COUNT)
            cell_axis[csr_paddr[4:3]] <= csr_pwdata[REG_W-1:0];
         pending <= point_q.size();
      end
   end

endmodule

// ----- dv/nearest_lattice_point_vector_tb.sv -----
// Testbench top: drives cells and scattering vectors into the block and gives the verdict.
`timescale 1ns / 1ps
module nearest_lattice_point_vector_tb;
   import nlpv_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] ADDR_AXIS_A = 5'd0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_AXIS_B = 5'd8;
   localparam logic [CSR_ADDR_W-1:0] ADDR_AXIS_C = 5'd16;
   localparam logic [CSR_ADDR_W-1:0] ADDR_NONE   = 5'd24;
   localparam int RANDOM_PER_PHASE = 160;
   localparam int PHASES           = 12;
   localparam int CYCLE_LIMIT      = 600000;

   typedef enum int {CELL_ZERO, CELL_CUBIC, CELL_HUGE, CELL_TINY, CELL_RANDOM} cell_kind_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // q_x, q_y, q_z
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // g_x, g_y, g_z, index_h, index_k, index_l, pad
   logic [RSP_USER_W-1:0] rsp_tuser;        // singular, overflow
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    errors;
   int                    pending;
   int                    cycles = 0;
   int                    tx_idle_pct = 6;
   int                    rx_idle_pct = 84;

   nearest_lattice_point_vector DUT (.*);

   nearest_lattice_point_vector_checker checker_i (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("nearest_lattice_point_vector_tb: done, errors");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_tready <= reset ? 1'b0 : ($urandom_range(99) >= rx_idle_pct);

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(negedge clock); while (!csr_pready);
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic logic [CSR_DATA_W-1:0] pack_axis(int x, int y, int z);
      logic [COMP_W-1:0] cx, cy, cz;
      cx = COMP_W'(x);
      cy = COMP_W'(y);
      cz = COMP_W'(z);
      return {1'($urandom_range(1)), cz, cy, cx};
   endfunction

   function automatic int rand_comp();
      if ($urandom_range(1))
         return int'($signed(21'($urandom)));
      return $urandom_range(16384) - 8192;
   endfunction

   task automatic drain();
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic load_cell(cell_kind_type kind);
      int v[9];
      for (int j = 0; j < 9; j++)
         v[j] = 0;
      case (kind)
         CELL_CUBIC: begin
            v[0] = 4096; v[4] = 4096; v[8] = 4096;
         end
         CELL_HUGE: begin
            v[0] = 1048575; v[4] = -1048576; v[8] = 1048575;
            v[1] = -1048576; v[5] = 1048575;
         end
         CELL_TINY: begin
            v[0] = 1; v[4] = -1; v[8] = 1;
         end
         CELL_RANDOM: begin
            for (int j = 0; j < 9; j++)
               v[j] = rand_comp();
            if ($urandom_range(3) == 0)
               for (int j = 0; j < 3; j++)
                  v[6+j] = v[j];
         end
         default: ;
      endcase
      csr_write(ADDR_AXIS_A, pack_axis(v[0], v[1], v[2]));
      csr_write(ADDR_AXIS_B, pack_axis(v[3], v[4], v[5]));
      csr_write(ADDR_AXIS_C, pack_axis(v[6], v[7], v[8]));
      csr_write(ADDR_NONE, {$urandom, $urandom});
      repeat (12) @(posedge clock);
   endtask

   task automatic send_request(logic [Q_W-1:0] qx, logic [Q_W-1:0] qy, logic [Q_W-1:0] qz);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {qz, qy, qx};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
   endtask

   function automatic logic [Q_W-1:0] rand_q();
      logic signed [Q_W-1:0] v;
      v = $urandom;
      if ($urandom_range(3) == 0)
         return v;
      return v >>> $urandom_range(24);
   endfunction

   initial begin
      cell_kind_type kind;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int p = 0; p < PHASES; p++) begin
         tx_idle_pct = (p < 4) ? 6 : (p < 8) ? 84 : 0;
         rx_idle_pct = (p < 4) ? 84 : (p < 8) ? 6 : 0;
         kind = (p < 4) ? cell_kind_type'(p) : (p == 8) ? CELL_TINY : CELL_RANDOM;
         drain();
         load_cell(kind);
         if (p < 4) begin
            send_request(32'h0, 32'h0, 32'h0);
            send_request(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
            send_request(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
            send_request(32'h0080_0000, 32'h0180_0000, 32'hFF80_0000);
            send_request(32'hFE80_0000, 32'h0280_0000, 32'hFD80_0000);
            send_request(32'h0100_0001, 32'hFF00_0000, 32'h0000_0001);
         end
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (p == 6 && n == RANDOM_PER_PHASE / 2) begin
               req_tvalid <= 1'b0;
               @(posedge clock);
               while (pending != 0) @(posedge clock);
            end
            send_request(rand_q(), rand_q(), rand_q());
         end
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (errors == 0)
         $display("nearest_lattice_point_vector_tb: done, clean");
      else
         $display("nearest_lattice_point_vector_tb: done, errors");
      $finish;
   end

endmodule
